// ----- src/baro_pressure_compensation_assert.svh -----
// Assertion macros shared by the compensation RTL.
// Expects clk and rst_n in the scope of each use.
`ifndef BARO_PRESSURE_COMPENSATION_ASSERT_SVH
`define BARO_PRESSURE_COMPENSATION_ASSERT_SVH

// Same-cycle implication.
`define BPC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define BPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/bpc_pkg.sv -----
// Types, constants and arithmetic helpers for the pressure compensation block.
// No dependencies.
`default_nettype none

package bpc_pkg;

  localparam int unsigned RAW_W    = 20;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 64;

  localparam logic [WORD_W-1:0] TEMP_OFFS  = 32'd64000;
  localparam logic [WORD_W-1:0] P_BASE     = 32'd1048576;
  localparam logic [WORD_W-1:0] P_SCALE    = 32'd3125;
  localparam logic [WORD_W-1:0] DIV_BIAS   = 32'd32768;

  localparam int unsigned FRONT_STAGES = 10;
  localparam int unsigned QDEPTH       = 2;
  localparam int unsigned QAW          = $clog2(QDEPTH);
  localparam int unsigned DIV_STEPS    = 32;
  localparam int unsigned DCNT_W       = $clog2(DIV_STEPS);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TEMP   = 2'd0,
    CFG_PRESSA = 2'd1,
    CFG_PRESSB = 2'd2,
    CFG_PRESSC = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_NUM, ST_SETUP, ST_DIV, ST_SQ, ST_MUL9, ST_SUM, ST_DONE
  } back_state_t;

  // Calibration words, already extended to 32 bits.
  typedef struct packed {
    logic [WORD_W-1:0] t1, t2, t3;
    logic [WORD_W-1:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
  } cal_t;

  // Front to back request.
  typedef struct packed {
    logic [WORD_W-1:0] tf;
    logic [WORD_W-1:0] div;
    logic [WORD_W-1:0] v2;
    logic [RAW_W-1:0]  adc_p;
  } item_t;

  function automatic logic [WORD_W-1:0] sx16(logic [15:0] w);
    return {{16{w[15]}}, w};
  endfunction

  function automatic logic [WORD_W-1:0] zx16(logic [15:0] w);
    return {16'd0, w};
  endfunction

  function automatic logic [WORD_W-1:0] asr32(logic [WORD_W-1:0] x, int unsigned n);
    return WORD_W'($signed(x) >>> n);
  endfunction

  // Low word of a 32x32 product; same bits for signed and unsigned.
  function automatic logic [WORD_W-1:0] mul32(logic [WORD_W-1:0] a, logic [WORD_W-1:0] b);
    logic [2*WORD_W-1:0] f;
    f = (2*WORD_W)'(a) * (2*WORD_W)'(b);
    return f[WORD_W-1:0];
  endfunction

  function automatic cal_t cal_unpack(logic [47:0] tc, logic [63:0] pa,
                                      logic [63:0] pb, logic [15:0] pc);
    cal_t c;
    c.t1 = zx16(tc[15:0]);
    c.t2 = sx16(tc[31:16]);
    c.t3 = sx16(tc[47:32]);
    c.p1 = zx16(pa[15:0]);
    c.p2 = sx16(pa[31:16]);
    c.p3 = sx16(pa[47:32]);
    c.p4 = sx16(pa[63:48]);
    c.p5 = sx16(pb[15:0]);
    c.p6 = sx16(pb[31:16]);
    c.p7 = sx16(pb[47:32]);
    c.p8 = sx16(pb[63:48]);
    c.p9 = sx16(pc);
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- src/bpc_if.sv -----
// Channel interfaces: raw input, compensated result, configuration write.
// Depends on bpc_pkg.
`default_nettype none

interface bpc_in_if;
  import bpc_pkg::*;
  logic             valid;
  logic             ready;
  logic [RAW_W-1:0] raw_pressure;
  logic [RAW_W-1:0] raw_temperature;
  modport source (output valid, raw_pressure, raw_temperature, input ready);
  modport sink   (input valid, raw_pressure, raw_temperature, output ready);
endinterface

interface bpc_out_if;
  import bpc_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [WORD_W-1:0]        pressure_pa;
  logic signed [WORD_W-1:0] fine_temperature;
  logic                     divisor_zero;
  modport source (output valid, pressure_pa, fine_temperature, divisor_zero, input ready);
  modport sink   (input valid, pressure_pa, fine_temperature, divisor_zero, output ready);
endinterface

interface bpc_cfg_if;
  import bpc_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- src/bpc_fifo.sv -----
// Small request queue between front and back.
// Depends on bpc_pkg and the assertion header.
`default_nettype none
`include "baro_pressure_compensation_assert.svh"

module bpc_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  bpc_pkg::item_t push_item,
  output logic           pop_valid,
  input  logic           pop_ready,
  output bpc_pkg::item_t pop_item
);
  import bpc_pkg::*;

  item_t          mem_r [QDEPTH];
  logic [QAW-1:0] wptr_r, rptr_r;
  logic [QAW:0]   cnt_r;
  logic           push, pop;

  assign push_ready = (cnt_r != (QAW+1)'(QDEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_item   = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) wptr_r <= (wptr_r == QAW'(QDEPTH-1)) ? '0 : wptr_r + 1'b1;
      if (pop)  rptr_r <= (rptr_r == QAW'(QDEPTH-1)) ? '0 : rptr_r + 1'b1;
      cnt_r <= cnt_r + (QAW+1)'(push) - (QAW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wptr_r] <= push_item;
  end

  `BPC_ASSERT_NOW(a_fifo_bound, 1'b1, cnt_r <= (QAW+1)'(QDEPTH), "queue count past depth")

endmodule

`default_nettype wire

// ----- src/bpc_front.sv -----
// Front pipeline: accepts raw pairs, computes fine temperature, divisor and offset.
// Depends on bpc_pkg and bpc_if.
`default_nettype none

module bpc_front (
  input  logic           clk,
  input  logic           rst_n,
  input  bpc_pkg::cal_t  cal,
  bpc_in_if.sink         in_ch,
  output logic           item_valid,
  input  logic           item_ready,
  output bpc_pkg::item_t item
);
  import bpc_pkg::*;

  logic [FRONT_STAGES-1:0] vld_r;
  logic                    en, take;
  logic [RAW_W-1:0]        adcp_r [FRONT_STAGES];
  logic [WORD_W-1:0]       tfp_r [FRONT_STAGES-2];
  logic [WORD_W-1:0]       adc_t, d, x, v1;
  logic [WORD_W-1:0]       s1_ma_r, s1_md_r, s2_a_r, s2_mb_r;
  logic [WORD_W-1:0]       s4_v1_r, s4_q_r, s5_q2_r, s5_m5_r, s5_m2_r;
  logic [WORD_W-1:0]       s6_m6_r, s6_m3_r, s6_m5_r, s6_m2_r;
  logic [WORD_W-1:0]       s7_v2a_r, s7_s1_r, s8_v2_r, s8_v1b_r;
  logic [WORD_W-1:0]       s9_m1_r, s9_v2_r, s10_div_r, s10_v2_r;

  // Whole pipe advances together; it holds only when the last stage is stuck.
  assign en          = !vld_r[FRONT_STAGES-1] || item_ready;
  assign in_ch.ready = en;
  assign take        = in_ch.valid && en;

  assign adc_t = WORD_W'(in_ch.raw_temperature);
  assign x     = (adc_t >> 3) - (cal.t1 << 1);
  assign d     = (adc_t >> 4) - cal.t1;
  assign v1    = asr32(tfp_r[0], 1) - TEMP_OFFS;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[FRONT_STAGES-2:0], take};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      adcp_r[0] <= in_ch.raw_pressure;
      for (int i = 1; i < FRONT_STAGES; i++) adcp_r[i] <= adcp_r[i-1];
      s1_ma_r  <= mul32(x, cal.t2);
      s1_md_r  <= mul32(d, d);
      s2_a_r   <= asr32(s1_ma_r, 11);
      s2_mb_r  <= mul32(asr32(s1_md_r, 12), cal.t3);
      tfp_r[0] <= s2_a_r + asr32(s2_mb_r, 14);
      for (int i = 1; i < FRONT_STAGES-2; i++) tfp_r[i] <= tfp_r[i-1];
      s4_v1_r  <= v1;
      s4_q_r   <= asr32(v1, 2);
      s5_q2_r  <= mul32(s4_q_r, s4_q_r);
      s5_m5_r  <= mul32(s4_v1_r, cal.p5);
      s5_m2_r  <= mul32(cal.p2, s4_v1_r);
      s6_m6_r  <= mul32(asr32(s5_q2_r, 11), cal.p6);
      s6_m3_r  <= mul32(cal.p3, asr32(s5_q2_r, 13));
      s6_m5_r  <= s5_m5_r;
      s6_m2_r  <= s5_m2_r;
      s7_v2a_r <= s6_m6_r + (s6_m5_r << 1);
      s7_s1_r  <= asr32(s6_m3_r, 3) + asr32(s6_m2_r, 1);
      s8_v2_r  <= asr32(s7_v2a_r, 2) + (cal.p4 << 16);
      s8_v1b_r <= asr32(s7_s1_r, 18);
      s9_m1_r  <= mul32(DIV_BIAS + s8_v1b_r, cal.p1);
      s9_v2_r  <= s8_v2_r;
      s10_div_r <= asr32(s9_m1_r, 15);
      s10_v2_r  <= s9_v2_r;
    end
  end

  assign item_valid = vld_r[FRONT_STAGES-1];
  assign item.tf    = tfp_r[FRONT_STAGES-3];
  assign item.div   = s10_div_r;
  assign item.v2    = s10_v2_r;
  assign item.adc_p = adcp_r[FRONT_STAGES-1];

endmodule

`default_nettype wire

// ----- src/bpc_back.sv -----
// Back end: pressure numerator, 32-step divider, nonlinear correction, result register.
// Depends on bpc_pkg, bpc_if and the assertion header.
`default_nettype none
`include "baro_pressure_compensation_assert.svh"

module bpc_back (
  input  logic           clk,
  input  logic           rst_n,
  input  bpc_pkg::cal_t  cal,
  input  logic           item_valid,
  output logic           item_pop,
  input  bpc_pkg::item_t item,
  bpc_out_if.source      out_ch
);
  import bpc_pkg::*;

  back_state_t       st_r, st_nxt;
  logic [DCNT_W-1:0] cnt_r, cnt_nxt;
  logic              ovld_r, ovld_nxt;
  item_t             cur_r, cur_nxt;
  logic              zf_r, zf_nxt, dbl_r, dbl_nxt, oflag_r, oflag_nxt;
  logic [WORD_W-1:0] p_r, p_nxt, num_r, num_nxt, rem_r, rem_nxt, quo_r, quo_nxt;
  logic [WORD_W-1:0] sq_r, sq_nxt, w2_r, w2_nxt, m9_r, m9_nxt, s_r, s_nxt;
  logic [WORD_W-1:0] opress_r, opress_nxt, otf_r, otf_nxt;
  logic [WORD_W:0]   rem_sh, rem_diff;
  logic              ge;

  always_comb begin
    st_nxt = st_r;  cnt_nxt = cnt_r;  ovld_nxt = ovld_r;  cur_nxt = cur_r;
    zf_nxt = zf_r;  dbl_nxt = dbl_r;  oflag_nxt = oflag_r;
    p_nxt = p_r;  num_nxt = num_r;  rem_nxt = rem_r;  quo_nxt = quo_r;
    sq_nxt = sq_r;  w2_nxt = w2_r;  m9_nxt = m9_r;  s_nxt = s_r;
    opress_nxt = opress_r;  otf_nxt = otf_r;
    item_pop = 1'b0;

    rem_sh   = {rem_r, num_r[WORD_W-1]};
    ge       = rem_sh >= {1'b0, cur_r.div};
    rem_diff = rem_sh - {1'b0, cur_r.div};

    if (ovld_r && out_ch.ready) ovld_nxt = 1'b0;

    case (st_r)
      ST_IDLE: begin
        if (item_valid) begin
          item_pop = 1'b1;
          cur_nxt  = item;
          st_nxt   = ST_NUM;
        end
      end
      ST_NUM: begin
        zf_nxt = (cur_r.div == '0);
        p_nxt  = mul32(P_BASE - WORD_W'(cur_r.adc_p) - asr32(cur_r.v2, 12), P_SCALE);
        st_nxt = (cur_r.div == '0) ? ST_DONE : ST_SETUP;
      end
      ST_SETUP: begin
        // Large numerators are divided first and doubled after.
        dbl_nxt = p_r[WORD_W-1];
        num_nxt = p_r[WORD_W-1] ? p_r : {p_r[WORD_W-2:0], 1'b0};
        rem_nxt = '0;
        quo_nxt = '0;
        cnt_nxt = '0;
        st_nxt  = ST_DIV;
      end
      ST_DIV: begin
        rem_nxt = ge ? rem_diff[WORD_W-1:0] : rem_sh[WORD_W-1:0];
        quo_nxt = {quo_r[WORD_W-2:0], ge};
        num_nxt = {num_r[WORD_W-2:0], 1'b0};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == DCNT_W'(DIV_STEPS-1)) begin
          p_nxt  = dbl_r ? {quo_nxt[WORD_W-2:0], 1'b0} : quo_nxt;
          st_nxt = ST_SQ;
        end
      end
      ST_SQ: begin
        sq_nxt = mul32(p_r >> 3, p_r >> 3);
        w2_nxt = mul32(p_r >> 2, cal.p8);
        st_nxt = ST_MUL9;
      end
      ST_MUL9: begin
        m9_nxt = mul32(cal.p9, sq_r >> 13);
        st_nxt = ST_SUM;
      end
      ST_SUM: begin
        s_nxt  = asr32(m9_r, 12) + asr32(w2_r, 13) + cal.p7;
        st_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!ovld_r || out_ch.ready) begin
          ovld_nxt   = 1'b1;
          opress_nxt = zf_r ? '0 : p_r + asr32(s_r, 4);
          oflag_nxt  = zf_r;
          otf_nxt    = cur_r.tf;
          st_nxt     = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= ST_IDLE;
      cnt_r  <= '0;
      ovld_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      cnt_r  <= cnt_nxt;
      ovld_r <= ovld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;  zf_r <= zf_nxt;  dbl_r <= dbl_nxt;  oflag_r <= oflag_nxt;
    p_r <= p_nxt;  num_r <= num_nxt;  rem_r <= rem_nxt;  quo_r <= quo_nxt;
    sq_r <= sq_nxt;  w2_r <= w2_nxt;  m9_r <= m9_nxt;  s_r <= s_nxt;
    opress_r <= opress_nxt;  otf_r <= otf_nxt;
  end

  assign out_ch.valid            = ovld_r;
  assign out_ch.pressure_pa      = opress_r;
  assign out_ch.fine_temperature = $signed(otf_r);
  assign out_ch.divisor_zero     = oflag_r;

  `BPC_ASSERT_NOW(a_zero_div_result, ovld_r && oflag_r, opress_r == '0, "zero divisor gave nonzero pressure")
  `BPC_ASSERT_NEXT(a_div_exit, st_r == ST_DIV && cnt_r == DCNT_W'(DIV_STEPS-1), st_r == ST_SQ, "divider overran")
  `BPC_ASSERT_NEXT(a_no_skip_div, st_r == ST_NUM && cur_r.div != '0, st_r == ST_SETUP, "nonzero divisor skipped divide")

endmodule

`default_nettype wire

// ----- src/baro_pressure_compensation.sv -----
// Top level of the barometric pressure compensation block: calibration registers,
// front pipeline, request queue and back end. Depends on bpc_pkg, bpc_if, bpc_fifo,
// bpc_front and bpc_back.
`default_nettype none

// Converts raw 20-bit pressure/temperature pairs into compensated pressure in pascals
// plus the fine temperature value, with the standard 32-bit integer compensation.
// A ten-stage front pipeline computes the fine temperature, the divisor and the offset
// term and drops each request into a two-entry queue; the back end forms the numerator,
// runs a restoring divider one quotient bit per cycle, then applies the nonlinear
// correction. The back end holds one item at a time from pop to result, so sustained
// throughput is set by the 32-step divider. A zero divisor skips the divide, returns
// pressure 0 and raises divisor_zero. The input accepts new pairs while the back end
// works and while a result waits on the output, until the front pipeline and queue fill.
// Calibration is written through the cfg channel (always ready) with index 0..3 for
// temperature words, pressure words P1..P4, P5..P8 and P9; write it only while idle.

module baro_pressure_compensation (
  input  logic       clk,
  input  logic       rst_n,
  bpc_in_if.sink     in_ch,
  bpc_out_if.source  out_ch,
  bpc_cfg_if.sink    cfg_ch
);
  import bpc_pkg::*;

  logic [47:0] tcal_r;
  logic [63:0] pcal_a_r, pcal_b_r;
  logic [15:0] pcal_c_r;
  cal_t        cal;
  item_t       f_item, b_item;
  logic        f_valid, f_ready, b_valid, b_pop;

  assign cfg_ch.ready = 1'b1;

  // Calibration registers; packed words are split and extended (T1 and P1 zero, the rest sign) once here.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tcal_r   <= '0;
      pcal_a_r <= '0;
      pcal_b_r <= '0;
      pcal_c_r <= '0;
    end else if (cfg_ch.valid) begin
      case (cfg_reg_t'(cfg_ch.index))
        CFG_TEMP:   tcal_r   <= cfg_ch.data[47:0];
        CFG_PRESSA: pcal_a_r <= cfg_ch.data;
        CFG_PRESSB: pcal_b_r <= cfg_ch.data;
        CFG_PRESSC: pcal_c_r <= cfg_ch.data[15:0];
        default: ;
      endcase
    end
  end

  assign cal = cal_unpack(tcal_r, pcal_a_r, pcal_b_r, pcal_c_r);

  bpc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cal        (cal),
    .in_ch      (in_ch),
    .item_valid (f_valid),
    .item_ready (f_ready),
    .item       (f_item)
  );

  bpc_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_item  (f_item),
    .pop_valid  (b_valid),
    .pop_ready  (b_pop),
    .pop_item   (b_item)
  );

  bpc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cal        (cal),
    .item_valid (b_valid),
    .item_pop   (b_pop),
    .item       (b_item),
    .out_ch     (out_ch)
  );

endmodule

`default_nettype wire

// ----- sim/tb_baro_pressure_compensation.sv -----
// Self-checking testbench for baro_pressure_compensation.
// Needs bpc_pkg, bpc_if and the RTL. A built-in predictor or a typed value checks each result.
`timescale 1ns / 100ps
`default_nettype none

module tb_baro_pressure_compensation;
  import bpc_pkg::*;

  localparam int HALF_PERIOD  = 10;
  localparam int IDLE_PCT     = 26;
  localparam int STALL_LIMIT  = 3000;   // cycles with no handshake at all
  localparam int DRAIN_CYCLES = 120;    // > block latency
  localparam int N_ZERO_ROWS  = 3;      // leading rows run with calibration at reset
  localparam int N_ROWS       = 11;
  localparam int ITEMS_PER_SET = 60;

  // One expected compensation result.
  typedef struct {
    logic [31:0] pressure;
    logic [31:0] t_fine;
    logic        div_zero;
  } comp_result_t;

  // Directed request; the expected result is typed in only where chk is set.
  typedef struct {
    logic [19:0]  raw_p;
    logic [19:0]  raw_t;
    bit           chk;
    comp_result_t res;
  } raw_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  bpc_in_if  in_if();
  bpc_out_if out_if();
  bpc_cfg_if cfg_if();

  baro_pressure_compensation dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if.sink),
    .out_ch (out_if.source),
    .cfg_ch (cfg_if.sink)
  );

  always #(HALF_PERIOD) clk = ~clk;

  // Calibration as the predictor sees it.
  logic [47:0] cal_temp;
  logic [63:0] cal_pa, cal_pb;
  logic [15:0] cal_p9;

  comp_result_t pending_q[$];
  int  mismatches = 0;
  int  quiet_cycles = 0;
  bit  calm = 1'b0;       // long stretch with no idling on either side
  raw_row_t rows[N_ROWS];

  function automatic bit go_idle();
    return !calm && ($urandom_range(0, 99) < IDLE_PCT);
  endfunction

  function automatic logic [31:0] sext16(logic [15:0] w);
    return {{16{w[15]}}, w};
  endfunction

  function automatic logic [31:0] sra(logic [31:0] x, int unsigned n);
    logic signed [31:0] s;
    s = x;
    return s >>> n;
  endfunction

  // Standard 32-bit integer compensation, wrapping as two's complement.
  function automatic comp_result_t compensate(logic [19:0] raw_p, logic [19:0] raw_t);
    comp_result_t r;
    logic [31:0] adc_p, adc_t, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [31:0] a, b, d, tf, v1, v2, q, q2, p, w1, w2, sq;
    adc_p = {12'd0, raw_p};
    adc_t = {12'd0, raw_t};
    t1 = {16'd0, cal_temp[15:0]};
    t2 = sext16(cal_temp[31:16]);
    t3 = sext16(cal_temp[47:32]);
    p1 = {16'd0, cal_pa[15:0]};
    p2 = sext16(cal_pa[31:16]);
    p3 = sext16(cal_pa[47:32]);
    p4 = sext16(cal_pa[63:48]);
    p5 = sext16(cal_pb[15:0]);
    p6 = sext16(cal_pb[31:16]);
    p7 = sext16(cal_pb[47:32]);
    p8 = sext16(cal_pb[63:48]);
    p9 = sext16(cal_p9);
    // fine temperature
    a = (adc_t >> 3) - (t1 << 1);
    a = sra(a * t2, 11);
    d = (adc_t >> 4) - t1;
    b = d * d;
    b = sra(sra(b, 12) * t3, 14);
    tf = a + b;
    // divisor and offset
    v1 = sra(tf, 1) - 32'd64000;
    q  = sra(v1, 2);
    q2 = q * q;
    v2 = sra(q2, 11) * p6;
    v2 = v2 + ((v1 * p5) << 1);
    v2 = sra(v2, 2) + (p4 << 16);
    a  = p3 * sra(q2, 13);
    b  = p2 * v1;
    v1 = sra(sra(a, 3) + sra(b, 1), 18);
    v1 = sra((32'd32768 + v1) * p1, 15);
    r.t_fine = tf;
    if (v1 == 32'd0) begin
      r.pressure = 32'd0;
      r.div_zero = 1'b1;
      return r;
    end
    p = ((32'd1048576 - adc_p) - sra(v2, 12)) * 32'd3125;
    if (p < 32'h8000_0000) p = (p << 1) / v1;
    else p = (p / v1) * 32'd2;
    sq = (p >> 3) * (p >> 3);
    w1 = sra(p9 * (sq >> 13), 12);
    w2 = sra((p >> 2) * p8, 13);
    r.pressure = p + sra(w1 + w2 + p7, 4);
    r.div_zero = 1'b0;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("[%0t] MISMATCH %s: got %h want %h", $realtime, what, got, want);
    mismatches++;
  endtask

  // Result checker.
  always @(posedge clk) begin
    comp_result_t w;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_q.size() == 0) begin
        report_mismatch("unexpected result, pressure", out_if.pressure_pa, 32'd0);
      end else begin
        w = pending_q.pop_front();
        if (out_if.pressure_pa !== w.pressure)
          report_mismatch("pressure_pa", out_if.pressure_pa, w.pressure);
        if (out_if.fine_temperature !== w.t_fine)
          report_mismatch("fine_temperature", out_if.fine_temperature, w.t_fine);
        if (out_if.divisor_zero !== w.div_zero)
          report_mismatch("divisor_zero", {31'd0, out_if.divisor_zero}, {31'd0, w.div_zero});
      end
    end
  end

  // Receiver back-pressure.
  always @(negedge clk) out_if.ready = rst_n && !go_idle();

  // Watchdog: counts cycles with no handshake on any channel.
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready) || !rst_n)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // One calibration write; mirrored into the predictor on the handshake.
  task automatic write_cal(cfg_reg_t idx, logic [63:0] value);
    @(negedge clk);
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.data  = value;
    do @(posedge clk); while (!cfg_if.ready);
    case (idx)
      CFG_TEMP:   cal_temp = value[47:0];
      CFG_PRESSA: cal_pa   = value;
      CFG_PRESSB: cal_pb   = value;
      CFG_PRESSC: cal_p9   = value[15:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  task automatic load_cal(logic [47:0] tc, logic [63:0] pa, logic [63:0] pb, logic [63:0] pc);
    wait (pending_q.size() == 0);
    write_cal(CFG_TEMP, {16'd0, tc});
    write_cal(CFG_PRESSA, pa);
    write_cal(CFG_PRESSB, pb);
    write_cal(CFG_PRESSC, pc);    // upper bits ignored by the block
  endtask

  // Send one request; chk selects a typed-in expectation over the predictor.
  task automatic send_raw(logic [19:0] rp, logic [19:0] rt, bit chk, comp_result_t typed);
    @(negedge clk);
    while (go_idle()) begin
      in_if.valid = 1'b0;
      @(negedge clk);
    end
    in_if.valid = 1'b1;
    in_if.raw_pressure = rp;
    in_if.raw_temperature = rt;
    do @(posedge clk); while (!in_if.ready);
    pending_q.push_back(chk ? typed : compensate(rp, rt));
  endtask

  task automatic end_burst();
    @(negedge clk);
    in_if.valid = 1'b0;
  endtask

  // Mostly sensor-like conversions, some anywhere in the 20-bit range.
  task automatic send_random(int n);
    comp_result_t none;
    logic [19:0] rp, rt;
    none = '{default: '0};
    repeat (n) begin
      if ($urandom_range(0, 99) < 70) begin
        rp = 20'd415148 + 20'($urandom_range(0, 200000)) - 20'd100000;
        rt = 20'd519888 + 20'($urandom_range(0, 100000)) - 20'd50000;
      end else begin
        rp = 20'($urandom);
        rt = 20'($urandom);
      end
      send_raw(rp, rt, 1'b0, none);
    end
    end_burst();
  endtask

  // Typical factory words: T1..T3, P1..P9.
  localparam logic [47:0] TYP_T  = {16'hFC18, 16'd26435, 16'd27504};
  localparam logic [63:0] TYP_PA = {16'd2855, 16'd3024, 16'hD643, 16'd36477};
  localparam logic [63:0] TYP_PB = {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140};
  localparam logic [63:0] TYP_PC = 64'd6000;

  initial begin
    comp_result_t zero_div;
    in_if.valid = 1'b0;
    in_if.raw_pressure = '0;
    in_if.raw_temperature = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = CFG_TEMP;
    cfg_if.data = '0;
    out_if.ready = 1'b0;
    cal_temp = '0;
    cal_pa = '0;
    cal_pb = '0;
    cal_p9 = '0;

    // With all calibration at zero, P1 = 0 forces a zero divisor and t_fine = 0.
    zero_div = '{pressure: 32'd0, t_fine: 32'd0, div_zero: 1'b1};
    rows = '{
      '{20'd0,      20'd0,      1'b1, zero_div},
      '{20'hFFFFF,  20'hFFFFF,  1'b1, zero_div},
      '{20'd415148, 20'd519888, 1'b1, zero_div},
      // typical calibration from here on
      '{20'd0,      20'd0,      1'b0, zero_div},
      '{20'hFFFFF,  20'd0,      1'b0, zero_div},
      '{20'd0,      20'hFFFFF,  1'b0, zero_div},
      '{20'hFFFFF,  20'hFFFFF,  1'b0, zero_div},
      '{20'd415148, 20'd519888, 1'b0, zero_div},
      '{20'h80000,  20'h80000,  1'b0, zero_div},
      '{20'h55555,  20'hAAAAA,  1'b0, zero_div},
      '{20'd1,      20'd1,      1'b0, zero_div}
    };

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: reset calibration, then typical calibration.
    for (int i = 0; i < N_ROWS; i++) begin
      if (i == N_ZERO_ROWS) begin
        end_burst();
        load_cal(TYP_T, TYP_PA, TYP_PB, TYP_PC);
      end
      send_raw(rows[i].raw_p, rows[i].raw_t, rows[i].chk, rows[i].res);
    end
    end_burst();

    // Random requests under typical calibration, no idling.
    calm = 1'b1;
    send_random(ITEMS_PER_SET);
    calm = 1'b0;

    // Extremes: all ones, most negative words, most positive words, P1 = 0 (zero divisor).
    load_cal('1, '1, '1, '1);
    send_random(ITEMS_PER_SET / 2);
    load_cal({16'h8000, 16'h8000, 16'hFFFF}, {{3{16'h8000}}, 16'hFFFF},
             {4{16'h8000}}, 64'hFFFF_FFFF_FFFF_8000);
    send_random(ITEMS_PER_SET / 2);
    load_cal({16'h7FFF, 16'h7FFF, 16'h0000}, {{3{16'h7FFF}}, 16'h0001},
             {4{16'h7FFF}}, 64'h7FFF);
    send_random(ITEMS_PER_SET / 2);
    load_cal(TYP_T, {TYP_PA[63:16], 16'd0}, TYP_PB, TYP_PC);
    send_random(ITEMS_PER_SET / 2);

    // Fully random calibration sets.
    repeat (5) begin
      load_cal({16'($urandom), $urandom}, {$urandom, $urandom},
               {$urandom, $urandom}, {$urandom, $urandom});
      send_random(ITEMS_PER_SET);
    end

    // Back to typical calibration for a final run.
    load_cal(TYP_T, TYP_PA, TYP_PB, TYP_PC);
    send_random(ITEMS_PER_SET);

    wait (pending_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire
